// File: hdl/mspag_pkg.sv
package mspag_pkg;

   // Field widths
   localparam int MAG_W       = 16;   // magnitudes, unsigned
   localparam int SNR_W       = 16;   // SNR values, unsigned Q8.8
   localparam int SNR_FRAC_W  = 8;
   localparam int GAIN_FRAC_W = 12;   // gain, unsigned Q4.12
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;

   typedef logic [MAG_W-1:0]      mag_type;
   typedef logic [SNR_W-1:0]      snr_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SMOOTHING = 4'd0,
      CSR_SNR_CAP   = 4'd1
   } csr_index_type;

   // Register reset values
   localparam csr_data_type SMOOTHING_RESET = 16'd64225;  // 0.98 in Q0.16
   localparam csr_data_type SNR_CAP_RESET   = 16'd10240;  // 40 in Q8.8

   // Fixed-point constants
   localparam snr_type        SNR_ONE    = 16'd256;     // 1.0 in Q8.8
   localparam logic [16:0]    UNITY_Q16  = 17'd65536;   // 1.0 in Q0.16
   localparam logic [15:0]    ROUND_Q16  = 16'h8000;    // half LSB before >> 16
   localparam logic [11:0]    ROUND_GAIN = 12'h800;     // half LSB before >> 12

endpackage

// File: hdl/mspag_if.sv
interface mspag_req_if
   import mspag_pkg::*;
();
   logic    valid;
   logic    ready;
   mag_type noisy_magnitude;
   mag_type noise_magnitude;
   logic    frame_end;

   modport source (output valid, output noisy_magnitude, output noise_magnitude,
                   output frame_end, input ready);
   modport sink   (input valid, input noisy_magnitude, input noise_magnitude,
                   input frame_end, output ready);
endinterface

interface mspag_rsp_if
   import mspag_pkg::*;
();
   logic    valid;
   logic    ready;
   mag_type clean_magnitude;
   logic    frame_end_out;

   modport source (output valid, output clean_magnitude, output frame_end_out,
                   input ready);
   modport sink   (input valid, input clean_magnitude, input frame_end_out,
                   output ready);
endinterface

interface mspag_csr_if
   import mspag_pkg::*;
();
   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/map_spectral_amplitude_gain.sv
// MAP spectral amplitude gain with a decision-directed prior SNR. One word per
// frequency bin goes in (noisy magnitude, noise magnitude, end of frame) and one
// word per bin comes out (clean magnitude, end of frame), in order. The block
// takes one bin per clock while the output is not held and no sweep runs; a bin
// is also held back while the same store entry (same bin of the same bank) is
// still in flight in the 106-stage pipeline, which happens when frames are so
// short that an entry comes back before its last result is written back. The
// posterior/previous SNR dividers, the 42-bit divider for the MAP term, the
// 22-step square root and the gain divider each produce one bit per stage.
// After reset the clean-magnitude store (2*BINS entries, one synchronous RAM)
// is swept to zero, while no bin is taken; register writes are taken at any time.
module map_spectral_amplitude_gain
   import mspag_pkg::*;
#(
   parameter int BINS = 256
) (
   input  logic        clock,
   input  logic        reset,
   mspag_req_if.sink   req_chan,
   mspag_rsp_if.source rsp_chan,
   mspag_csr_if.sink   csr_chan
);

   localparam int BIN_W    = $clog2(BINS);
   localparam int DEPTH    = 2 * BINS;
   localparam int AW       = $clog2(DEPTH);
   localparam int SQ_W     = 2 * MAG_W;
   localparam int PQ_NW    = SQ_W + SNR_FRAC_W + 1;
   localparam int PQ_LAT   = SNR_W + 1;
   localparam int LIN_W    = 2 * SNR_W + 1;
   localparam int SCALE_SH = SNR_FRAC_W + 1;
   localparam int IN_NW    = LIN_W + SCALE_SH;
   localparam int IN_LAT   = IN_NW + 1;
   localparam int IN_SW    = SQ_W + SNR_W + MAG_W + 2;
   localparam int S_W      = IN_NW + 1;
   localparam int SQ_IW    = S_W + (S_W % 2);
   localparam int RT_W     = SQ_IW / 2;
   localparam int SQ_SW    = SNR_W + MAG_W + 2;
   localparam int N_W      = RT_W + 1;
   localparam int G_NW     = N_W + GAIN_FRAC_W + 1;
   localparam int G_DW     = SNR_W + 2;
   localparam int G_LAT    = SNR_W + 1;
   localparam int G_SW     = MAG_W + 2;
   localparam int CL_W     = SQ_W + 1 - GAIN_FRAC_W;
   localparam int LAT      = 2 + PQ_LAT + 4 + IN_LAT + RT_W + G_LAT + 1;

   // configuration
   csr_data_type smooth_ff;
   csr_data_type cap_ff;

   // frame position and store clearing
   logic [BIN_W-1:0] bin_ff;
   logic             bank_ff;
   logic             clr_busy_ff;
   logic [AW-1:0]    clr_cnt_ff;
   logic [AW-1:0]    cur_addr;

   // pipeline tracking
   logic [LAT-1:0]   vld_ff;
   logic [AW-1:0]    addr_ff [LAT];
   logic             adv;
   logic             hazard;
   logic             accept;
   logic             wr_item;

   // store ports
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   mag_type          ram_wdata;
   mag_type          prev_mag;

   // front stages
   mag_type          s0_noisy_ff;
   mag_type          s0_noise_ff;
   logic             s0_fend_ff;
   logic [SQ_W-1:0]  s1_noisy_sq_ff;
   logic [SQ_W-1:0]  s1_noise_sq_ff;
   logic [SQ_W-1:0]  s1_prev_sq_ff;
   mag_type          s1_noisy_ff;
   logic             s1_fend_ff;

   // SNR dividers
   snr_type          d_post;
   snr_type          d_prev;
   mag_type          d_noisy;
   logic             d_fend;

   // prior SNR stages
   snr_type          p_cap;
   snr_type          excess;
   snr_type          x0_p_ff;
   snr_type          x0_excess_ff;
   snr_type          x0_q_ff;
   mag_type          x0_noisy_ff;
   logic             x0_fend_ff;
   logic [SQ_W-1:0]  x1_prod_a_ff;
   logic [SQ_W:0]    x1_prod_b_ff;
   snr_type          x1_p_ff;
   mag_type          x1_noisy_ff;
   logic             x1_fend_ff;
   logic [SQ_W+1:0]  prior_sum;
   snr_type          x2_prior_ff;
   snr_type          x2_p_ff;
   mag_type          x2_noisy_ff;
   logic             x2_fend_ff;
   logic [SQ_W-1:0]  x3_xsq_ff;
   logic [LIN_W-1:0] x3_lin_ff;
   snr_type          x3_prior_ff;
   snr_type          x3_p_ff;
   mag_type          x3_noisy_ff;
   logic             x3_fend_ff;

   // MAP term, root, gain
   logic [IN_NW-1:0] in_quo;
   logic [IN_SW-1:0] in_aux_out;
   logic [SQ_W-1:0]  n_xsq;
   snr_type          n_prior;
   mag_type          n_noisy;
   logic             n_fend;
   logic             n_pz;
   logic [SQ_IW-1:0] rad;
   logic [RT_W-1:0]  root;
   logic [SQ_SW-1:0] sq_aux_out;
   snr_type          r_prior;
   mag_type          r_noisy;
   logic             r_fend;
   logic             r_pz;
   logic [N_W-1:0]   g_n;
   logic [SNR_W:0]   half_den;
   logic [G_NW-1:0]  g_num;
   snr_type          g_quo;
   logic [G_SW-1:0]  g_aux_out;
   mag_type          g_noisy;
   logic             g_fend;
   logic             g_pz;
   snr_type          gain;
   logic [SQ_W-1:0]  g1_prod_ff;
   logic             g1_fend_ff;
   logic [SQ_W:0]    clean_sum;
   logic [CL_W-1:0]  clean_wide;
   mag_type          clean;

   // output register
   logic             rsp_valid_ff;
   mag_type          rsp_clean_ff;
   logic             rsp_fend_ff;

   // ---------------------------------------------------------------------
   // configuration writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= SMOOTHING_RESET;
         cap_ff    <= SNR_CAP_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_SMOOTHING: smooth_ff <= csr_chan.data;
            CSR_SNR_CAP:   cap_ff    <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // handshake and interlock against in-flight store entries
   assign cur_addr = bank_ff ? AW'(BINS) + AW'(bin_ff) : AW'(bin_ff);
   assign adv      = !(rsp_valid_ff && !rsp_chan.ready && vld_ff[LAT-1]);

   always_comb begin
      hazard = 1'b0;
      for (int k = 0; k < LAT; k++) begin
         if (vld_ff[k] && (addr_ff[k] == cur_addr)) begin
            hazard = 1'b1;
         end
      end
   end

   assign req_chan.ready = !clr_busy_ff && adv && !hazard;
   assign accept         = req_chan.valid && req_chan.ready;
   assign wr_item        = adv && vld_ff[LAT-1];

   // control: frame position, clearing sweep, pipeline valids, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff       <= '0;
         bank_ff      <= 1'b0;
         clr_busy_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (req_chan.frame_end) begin
               bin_ff  <= '0;
               bank_ff <= !bank_ff;
            end else if (bin_ff == BIN_W'(BINS - 1)) begin
               bin_ff <= '0;
            end else begin
               bin_ff <= bin_ff + BIN_W'(1);
            end
         end
         if (clr_busy_ff) begin
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end else begin
               clr_cnt_ff <= clr_cnt_ff + AW'(1);
            end
         end
         if (adv) begin
            vld_ff <= {vld_ff[LAT-2:0], accept};
         end
         if (wr_item) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // advance store addresses with the pipeline
   always_ff @(posedge clock) begin
      if (adv) begin
         addr_ff[0] <= cur_addr;
         for (int k = 1; k < LAT; k++) begin
            addr_ff[k] <= addr_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // clean-magnitude store: read at accept, write back as the result leaves
   assign ram_we    = clr_busy_ff || wr_item;
   assign ram_waddr = clr_busy_ff ? clr_cnt_ff : addr_ff[LAT-1];
   assign ram_wdata = clr_busy_ff ? '0 : clean;

   mspag_ram #(
      .WIDTH(MAG_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (adv),
      .rd_addr (cur_addr),
      .rd_data (prev_mag)
   );

   // ---------------------------------------------------------------------
   // capture the word, then square the magnitudes
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_noisy_ff    <= req_chan.noisy_magnitude;
         s0_noise_ff    <= req_chan.noise_magnitude;
         s0_fend_ff     <= req_chan.frame_end;
         s1_noisy_sq_ff <= SQ_W'(s0_noisy_ff) * SQ_W'(s0_noisy_ff);
         s1_noise_sq_ff <= SQ_W'(s0_noise_ff) * SQ_W'(s0_noise_ff);
         s1_prev_sq_ff  <= SQ_W'(prev_mag) * SQ_W'(prev_mag);
         s1_noisy_ff    <= s0_noisy_ff;
         s1_fend_ff     <= s0_fend_ff;
      end
   end

   // posterior SNR, rounded, saturated
   mspag_div #(
      .NW(PQ_NW), .DW(SQ_W), .QW(SNR_W), .SW(MAG_W)
   ) u_div_post (
      .clock   (clock),
      .en      (adv),
      .num     ((PQ_NW'(s1_noisy_sq_ff) << SNR_FRAC_W) + PQ_NW'(s1_noise_sq_ff >> 1)),
      .den     (s1_noise_sq_ff),
      .aux     (s1_noisy_ff),
      .quo     (d_post),
      .aux_out (d_noisy)
   );

   // SNR of the output from two frames back, rounded, saturated
   mspag_div #(
      .NW(PQ_NW), .DW(SQ_W), .QW(SNR_W), .SW(1)
   ) u_div_prev (
      .clock   (clock),
      .en      (adv),
      .num     ((PQ_NW'(s1_prev_sq_ff) << SNR_FRAC_W) + PQ_NW'(s1_noise_sq_ff >> 1)),
      .den     (s1_noise_sq_ff),
      .aux     (s1_fend_ff),
      .quo     (d_prev),
      .aux_out (d_fend)
   );

   // ---------------------------------------------------------------------
   // cap posterior SNR, mix the decision-directed prior
   assign p_cap     = (d_post > cap_ff) ? cap_ff : d_post;
   assign excess    = (p_cap > SNR_ONE) ? p_cap - SNR_ONE : '0;
   assign prior_sum = (SQ_W+2)'(x1_prod_a_ff) + (SQ_W+2)'(x1_prod_b_ff)
                    + (SQ_W+2)'(ROUND_Q16);

   always_ff @(posedge clock) begin
      if (adv) begin
         x0_p_ff      <= p_cap;
         x0_excess_ff <= excess;
         x0_q_ff      <= d_prev;
         x0_noisy_ff  <= d_noisy;
         x0_fend_ff   <= d_fend;
         x1_prod_a_ff <= SQ_W'(smooth_ff) * SQ_W'(x0_q_ff);
         x1_prod_b_ff <= (SQ_W+1)'(UNITY_Q16 - {1'b0, smooth_ff}) * (SQ_W+1)'(x0_excess_ff);
         x1_p_ff      <= x0_p_ff;
         x1_noisy_ff  <= x0_noisy_ff;
         x1_fend_ff   <= x0_fend_ff;
         x2_prior_ff  <= SNR_W'(prior_sum >> 16);
         x2_p_ff      <= x1_p_ff;
         x2_noisy_ff  <= x1_noisy_ff;
         x2_fend_ff   <= x1_fend_ff;
         x3_xsq_ff    <= SQ_W'(x2_prior_ff) * SQ_W'(x2_prior_ff);
         x3_lin_ff    <= LIN_W'(x2_prior_ff + (SNR_W+1)'(SNR_ONE)) * LIN_W'(x2_prior_ff);
         x3_prior_ff  <= x2_prior_ff;
         x3_p_ff      <= x2_p_ff;
         x3_noisy_ff  <= x2_noisy_ff;
         x3_fend_ff   <= x2_fend_ff;
      end
   end

   // floor(512*(1+x)*x / p)
   mspag_div #(
      .NW(IN_NW), .DW(SNR_W), .QW(IN_NW), .SW(IN_SW)
   ) u_div_map (
      .clock   (clock),
      .en      (adv),
      .num     (IN_NW'(x3_lin_ff) << SCALE_SH),
      .den     (x3_p_ff),
      .aux     ({x3_xsq_ff, x3_prior_ff, x3_noisy_ff, x3_fend_ff, (x3_p_ff == '0)}),
      .quo     (in_quo),
      .aux_out (in_aux_out)
   );

   assign {n_xsq, n_prior, n_noisy, n_fend, n_pz} = in_aux_out;
   assign rad = SQ_IW'(n_xsq) + SQ_IW'(in_quo);

   mspag_sqrt #(
      .IW(SQ_IW), .SW(SQ_SW)
   ) u_sqrt (
      .clock   (clock),
      .en      (adv),
      .rad     (rad),
      .aux     ({n_prior, n_noisy, n_fend, n_pz}),
      .root    (root),
      .aux_out (sq_aux_out)
   );

   assign {r_prior, r_noisy, r_fend, r_pz} = sq_aux_out;
   assign g_n      = N_W'(r_prior) + N_W'(root);
   assign half_den = (SNR_W+1)'(r_prior) + (SNR_W+1)'(SNR_ONE);
   assign g_num    = (G_NW'(g_n) << GAIN_FRAC_W) + G_NW'(half_den);

   // gain = round((x + root) / (2(1+x))) in Q4.12, saturated
   mspag_div #(
      .NW(G_NW), .DW(G_DW), .QW(SNR_W), .SW(G_SW)
   ) u_div_gain (
      .clock   (clock),
      .en      (adv),
      .num     (g_num),
      .den     ({half_den, 1'b0}),
      .aux     ({r_noisy, r_fend, r_pz}),
      .quo     (g_quo),
      .aux_out (g_aux_out)
   );

   assign {g_noisy, g_fend, g_pz} = g_aux_out;
   assign gain = g_pz ? '0 : g_quo;

   // ---------------------------------------------------------------------
   // apply the gain, round and saturate
   always_ff @(posedge clock) begin
      if (adv) begin
         g1_prod_ff <= SQ_W'(gain) * SQ_W'(g_noisy);
         g1_fend_ff <= g_fend;
      end
   end

   assign clean_sum  = (SQ_W+1)'(g1_prod_ff) + (SQ_W+1)'(ROUND_GAIN);
   assign clean_wide = clean_sum[SQ_W:GAIN_FRAC_W];
   assign clean      = (|clean_wide[CL_W-1:MAG_W]) ? '1 : clean_wide[MAG_W-1:0];

   // load the output register
   always_ff @(posedge clock) begin
      if (wr_item) begin
         rsp_clean_ff <= clean;
         rsp_fend_ff  <= g1_fend_ff;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.clean_magnitude = rsp_clean_ff;
   assign rsp_chan.frame_end_out   = rsp_fend_ff;

   // ---------------------------------------------------------------------
   a_no_read_of_writeback : assert property (@(posedge clock) disable iff (reset)
      (accept && wr_item) |-> (cur_addr != addr_ff[LAT-1]))
      else $error("bin read while its entry is written back");

   a_stall_holds_pipe : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready && vld_ff[LAT-1]) |=> $stable(vld_ff))
      else $error("pipeline moved while output held");

   a_result_from_pipe : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(wr_item))
      else $error("result without a finished bin");

   a_clear_pipe_empty : assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> (vld_ff == '0))
      else $error("bin in flight during store clearing");

   a_bin_range : assert property (@(posedge clock) disable iff (reset)
      bin_ff <= BIN_W'(BINS - 1))
      else $error("bin counter out of range");

endmodule

// File: hdl/mspag_ram.sv
module mspag_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one entry, read one entry into the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/mspag_div.sv
module mspag_div
   import mspag_pkg::*;
#(
   parameter int NW = 41,   // numerator width
   parameter int DW = 32,   // divisor width
   parameter int QW = 16,   // quotient bits kept; larger quotients saturate
   parameter int SW = 1     // side word carried along
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [SW-1:0] aux,
   output logic [QW-1:0] quo,
   output logic [SW-1:0] aux_out
);

   localparam int CW = (NW > DW) ? NW : DW;
   localparam int NS = QW + 1;

   logic [DW-1:0] rem_ff [NS];
   logic [DW-1:0] rem_in [NS];
   logic [QW-1:0] low_ff [NS];
   logic [QW-1:0] low_in [NS];
   logic [QW-1:0] quo_ff [NS];
   logic [QW-1:0] quo_in [NS];
   logic [DW-1:0] den_ff [NS];
   logic [DW-1:0] den_in [NS];
   logic [SW-1:0] aux_ff [NS];
   logic [SW-1:0] aux_in [NS];
   logic [NS-1:0] ovf_ff;
   logic [NS-1:0] ovf_in;
   logic [DW:0]   trial  [NS];

   always_comb begin
      // front stage: range check, seed remainder with the high numerator bits
      ovf_in[0] = CW'(num >> QW) >= CW'(den);
      rem_in[0] = ovf_in[0] ? '0 : DW'(num >> QW);
      low_in[0] = num[QW-1:0];
      quo_in[0] = '0;
      den_in[0] = den;
      aux_in[0] = aux;
      trial[0]  = '0;
      // one quotient bit per stage
      for (int k = 1; k < NS; k++) begin
         trial[k]  = {rem_ff[k-1], low_ff[k-1][QW-1]};
         low_in[k] = low_ff[k-1] << 1;
         den_in[k] = den_ff[k-1];
         aux_in[k] = aux_ff[k-1];
         ovf_in[k] = ovf_ff[k-1];
         if (trial[k] >= {1'b0, den_ff[k-1]}) begin
            rem_in[k] = DW'(trial[k] - {1'b0, den_ff[k-1]});
            quo_in[k] = (quo_ff[k-1] << 1) | QW'(1);
         end else begin
            rem_in[k] = DW'(trial[k]);
            quo_in[k] = quo_ff[k-1] << 1;
         end
      end
   end

   // advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff <= ovf_in;
         for (int k = 0; k < NS; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= den_in[k];
            aux_ff[k] <= aux_in[k];
         end
      end
   end

   assign quo     = ovf_ff[NS-1] ? '1 : quo_ff[NS-1];
   assign aux_out = aux_ff[NS-1];

endmodule

// File: hdl/mspag_sqrt.sv
module mspag_sqrt
   import mspag_pkg::*;
#(
   parameter int IW = 44,   // radicand width, even
   parameter int SW = 1     // side word carried along
) (
   input  logic              clock,
   input  logic              en,
   input  logic [IW-1:0]     rad,
   input  logic [SW-1:0]     aux,
   output logic [IW/2-1:0]   root,
   output logic [SW-1:0]     aux_out
);

   localparam int RW = IW / 2;

   typedef struct packed {
      logic [RW:0]   rem;
      logic [RW-1:0] root;
   } step_type;

   // one root bit: bring down a bit pair and try root*4+1
   function automatic step_type sq_step(input logic [RW:0] rem, input logic [RW-1:0] rt,
                                        input logic [1:0] pair);
      logic [RW+2:0] cur;
      logic [RW+2:0] trial;
      step_type      res;
      cur   = {rem, pair};
      trial = (RW+3)'({rt, 2'b01});
      if (cur >= trial) begin
         res.rem  = (RW+1)'(cur - trial);
         res.root = (rt << 1) | RW'(1);
      end else begin
         res.rem  = (RW+1)'(cur);
         res.root = rt << 1;
      end
      return res;
   endfunction

   step_type      st_ff  [RW];
   step_type      st_in  [RW];
   logic [IW-1:0] bits_ff [RW];
   logic [IW-1:0] bits_in [RW];
   logic [SW-1:0] aux_ff [RW];
   logic [SW-1:0] aux_in [RW];

   always_comb begin
      st_in[0]   = sq_step('0, '0, rad[IW-1:IW-2]);
      bits_in[0] = rad << 2;
      aux_in[0]  = aux;
      for (int k = 1; k < RW; k++) begin
         st_in[k]   = sq_step(st_ff[k-1].rem, st_ff[k-1].root, bits_ff[k-1][IW-1:IW-2]);
         bits_in[k] = bits_ff[k-1] << 2;
         aux_in[k]  = aux_ff[k-1];
      end
   end

   // advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < RW; k++) begin
            st_ff[k]   <= st_in[k];
            bits_ff[k] <= bits_in[k];
            aux_ff[k]  <= aux_in[k];
         end
      end
   end

   assign root    = st_ff[RW-1].root;
   assign aux_out = aux_ff[RW-1];

endmodule
